// ===== rtl/srwm_pkg.sv =====
// srwm_pkg: shared types, codes and helpers for the serial register master.
// No dependencies; used by every other file in rtl/ except srwm_if.
package srwm_pkg;

  // action codes on the request channel
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // low half of a read request word
  localparam logic [15:0] RD_REQ_LOW = 16'd31;

  // configuration port
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned TICKS_W   = 16;
  localparam logic        CFG_IDX_PHASE_TICKS = 1'b0;   // paddr[2]
  localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = 16'd1;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ,
    CMD_NONE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_LATCH,
    ST_RECV
  } stage_t;

  // classified request, minus the shift word
  typedef struct packed {
    cmd_kind_t kind;
    logic      din;
  } cmd_t;

  typedef struct packed {
    logic clk;
    logic data;
    logic le;
  } pins_t;

  typedef struct packed {
    logic        clock_pin;
    logic        data_pin;
    logic        latch_pin;
    logic        busy_res;
    logic        read_valid;
    logic [31:0] read_data;
    logic        command_rejected;
  } result_t;

  function automatic pins_t pins_for(input stage_t stage, input logic msb,
                                     input logic [1:0] phase);
    pins_t p;
    p = '0;
    unique case (stage)
      ST_SEND: begin
        p.data = msb;
        p.clk  = (phase == 2'd1);
      end
      ST_LATCH: p.le  = (phase == 2'd1);
      ST_RECV:  p.clk = (phase < 2'd2);
      default:  p = '0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/srwm_if.sv =====
// srwm_if: request and result channel interfaces (valid/ready).
// Depends on nothing; carries the fields of one request or one result.
interface srwm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] write_word;
  logic [15:0] reg_address;
  logic        data_in_pin;

  modport source (output valid, action, write_word, reg_address, data_in_pin,
                  input ready);
  modport sink   (input valid, action, write_word, reg_address, data_in_pin,
                  output ready);
endinterface

interface srwm_out_if;
  logic        valid;
  logic        ready;
  logic        clock_pin;
  logic        data_pin;
  logic        latch_pin;
  logic        busy_res;
  logic        read_valid;
  logic [31:0] read_data;
  logic        command_rejected;

  modport source (output valid, clock_pin, data_pin, latch_pin, busy_res, read_valid,
                  read_data, command_rejected, input ready);
  modport sink   (input valid, clock_pin, data_pin, latch_pin, busy_res, read_valid,
                  read_data, command_rejected, output ready);
endinterface

// ===== rtl/srwm_front.sv =====
// srwm_front: accepts requests and classifies them, building the shift word.
// Depends on srwm_pkg and srwm_in_if; feeds srwm_queue.
module srwm_front #(
  parameter int unsigned WORD_BITS = 32
) (
  srwm_in_if.sink                  in_ch,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output srwm_pkg::cmd_t           cmd,
  output logic [WORD_BITS-1:0]     cmd_word
);

  logic [63:0] wide_word;

  assign cmd_valid   = in_ch.valid;
  assign in_ch.ready = cmd_ready;

  always_comb begin
    wide_word = '0;
    cmd.din   = in_ch.data_in_pin;
    unique case (in_ch.action)
      srwm_pkg::ACT_TICK: begin
        cmd.kind = srwm_pkg::CMD_TICK;
      end
      srwm_pkg::ACT_WRITE: begin
        cmd.kind  = srwm_pkg::CMD_WRITE;
        wide_word = {32'd0, in_ch.write_word};
      end
      srwm_pkg::ACT_READ: begin
        cmd.kind  = srwm_pkg::CMD_READ;
        wide_word = {32'd0, in_ch.reg_address, srwm_pkg::RD_REQ_LOW};
      end
      default: begin
        cmd.kind = srwm_pkg::CMD_NONE;
      end
    endcase
  end

  assign cmd_word = wide_word[WORD_BITS-1:0];

endmodule

// ===== rtl/srwm_queue.sv =====
// srwm_queue: two-entry request queue between front and back.
// Depends on srwm_pkg.
module srwm_queue #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  srwm_pkg::cmd_t        push_cmd,
  input  logic [WORD_BITS-1:0]  push_word,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output srwm_pkg::cmd_t        pop_cmd,
  output logic [WORD_BITS-1:0]  pop_word
);

  srwm_pkg::cmd_t        cmd_q_r  [2];
  logic [WORD_BITS-1:0]  word_q_r [2];
  logic [1:0]            count_r, count_nxt;
  logic                  wr_ptr_r, rd_ptr_r;
  logic                  push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = cmd_q_r[rd_ptr_r];
  assign pop_word   = word_q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r]  <= push_cmd;
      word_q_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== rtl/srwm_back.sv =====
// srwm_back: pin sequencer. Runs one queued request per cycle unless the result stalls,
// and registers the result. Depends on srwm_pkg and srwm_out_if; fed by srwm_queue.
module srwm_back #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [srwm_pkg::TICKS_W-1:0]    phase_ticks,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  srwm_pkg::cmd_t                  cmd,
  input  logic [WORD_BITS-1:0]            cmd_word,
  srwm_out_if.source                      out_ch
);

  localparam int unsigned BCW = $clog2(WORD_BITS);
  localparam logic [BCW-1:0] LAST_BIT = BCW'(WORD_BITS - 1);

  srwm_pkg::stage_t           stage_r, stage_nxt;
  logic [WORD_BITS-1:0]       out_shift_r, out_shift_nxt;
  logic [WORD_BITS-1:0]       in_shift_r, in_shift_nxt;
  logic [BCW-1:0]             bit_count_r, bit_count_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [srwm_pkg::TICKS_W-1:0] tick_count_r, tick_count_nxt;
  logic                       is_read_r, is_read_nxt;
  logic                       out_valid_r;
  srwm_pkg::result_t          res_r, res_nxt;

  logic                       pop, active, is_start, phase_end, last_phase, last_bit;
  logic                       done;
  logic [srwm_pkg::TICKS_W:0] tc_inc, limit;
  logic [63:0]                rd_wide;
  srwm_pkg::pins_t            pins;

  assign cmd_ready  = !out_valid_r || out_ch.ready;
  assign pop        = cmd_valid && cmd_ready;
  assign active     = (stage_r != srwm_pkg::ST_IDLE);
  assign is_start   = (cmd.kind == srwm_pkg::CMD_WRITE) || (cmd.kind == srwm_pkg::CMD_READ);
  assign tc_inc     = {1'b0, tick_count_r} + (srwm_pkg::TICKS_W+1)'(1);
  // zero ticks behaves as one
  assign limit      = (phase_ticks == '0) ? (srwm_pkg::TICKS_W+1)'(1) : {1'b0, phase_ticks};
  assign phase_end  = (cmd.kind == srwm_pkg::CMD_TICK) && active && (tc_inc >= limit);
  assign last_phase = (phase_r == 2'd2);
  assign last_bit   = (bit_count_r == LAST_BIT);

  // next stage
  always_comb begin
    stage_nxt = stage_r;
    if (pop) begin
      if (is_start && !active) begin
        stage_nxt = srwm_pkg::ST_SEND;
      end else if (phase_end && last_phase) begin
        unique case (stage_r)
          srwm_pkg::ST_SEND:  if (last_bit) stage_nxt = srwm_pkg::ST_LATCH;
          srwm_pkg::ST_LATCH: stage_nxt = is_read_r ? srwm_pkg::ST_RECV : srwm_pkg::ST_IDLE;
          srwm_pkg::ST_RECV:  if (last_bit) stage_nxt = srwm_pkg::ST_IDLE;
          default:            stage_nxt = stage_r;
        endcase
      end
    end
  end

  // datapath and result
  always_comb begin
    out_shift_nxt  = out_shift_r;
    in_shift_nxt   = in_shift_r;
    bit_count_nxt  = bit_count_r;
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    is_read_nxt    = is_read_r;
    done           = 1'b0;
    if (pop) begin
      if (is_start && !active) begin
        out_shift_nxt  = cmd_word;
        in_shift_nxt   = '0;
        bit_count_nxt  = '0;
        phase_nxt      = '0;
        tick_count_nxt = '0;
        is_read_nxt    = (cmd.kind == srwm_pkg::CMD_READ);
      end else if (cmd.kind == srwm_pkg::CMD_TICK && active) begin
        if (!phase_end) begin
          tick_count_nxt = tc_inc[srwm_pkg::TICKS_W-1:0];
        end else begin
          tick_count_nxt = '0;
          // readback sampled at the end of the first clock-high phase
          if (stage_r == srwm_pkg::ST_RECV && phase_r == 2'd0) begin
            in_shift_nxt = {in_shift_r[WORD_BITS-2:0], cmd.din};
          end
          phase_nxt = last_phase ? 2'd0 : phase_r + 2'd1;
          if (last_phase) begin
            unique case (stage_r)
              srwm_pkg::ST_SEND: begin
                out_shift_nxt = {out_shift_r[WORD_BITS-2:0], 1'b0};
                bit_count_nxt = last_bit ? '0 : bit_count_r + BCW'(1);
              end
              srwm_pkg::ST_LATCH: begin
                bit_count_nxt = '0;
              end
              srwm_pkg::ST_RECV: begin
                bit_count_nxt = last_bit ? '0 : bit_count_r + BCW'(1);
                if (last_bit) begin
                  is_read_nxt = 1'b0;
                  done        = 1'b1;
                end
              end
              default: bit_count_nxt = bit_count_r;
            endcase
          end
        end
      end
    end
  end

  assign pins    = srwm_pkg::pins_for(stage_nxt, out_shift_nxt[WORD_BITS-1], phase_nxt);
  assign rd_wide = 64'(in_shift_nxt);

  always_comb begin
    res_nxt.clock_pin        = pins.clk;
    res_nxt.data_pin         = pins.data;
    res_nxt.latch_pin        = pins.le;
    res_nxt.busy_res         = (stage_nxt != srwm_pkg::ST_IDLE);
    res_nxt.read_valid       = done;
    res_nxt.read_data        = done ? rd_wide[31:0] : 32'd0;
    res_nxt.command_rejected = is_start && active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r      <= srwm_pkg::ST_IDLE;
      out_shift_r  <= '0;
      in_shift_r   <= '0;
      bit_count_r  <= '0;
      phase_r      <= '0;
      tick_count_r <= '0;
      is_read_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      stage_r      <= stage_nxt;
      out_shift_r  <= out_shift_nxt;
      in_shift_r   <= in_shift_nxt;
      bit_count_r  <= bit_count_nxt;
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      is_read_r    <= is_read_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.clock_pin        = res_r.clock_pin;
  assign out_ch.data_pin         = res_r.data_pin;
  assign out_ch.latch_pin        = res_r.latch_pin;
  assign out_ch.busy_res         = res_r.busy_res;
  assign out_ch.read_valid       = res_r.read_valid;
  assign out_ch.read_data        = res_r.read_data;
  assign out_ch.command_rejected = res_r.command_rejected;

endmodule

// ===== rtl/serial_register_write_read_master.sv =====
// Serial register master for a three-wire clock/data/latch-enable bus. Every request
// (tick, start write, start read) yields one result request carrying the pin levels,
// busy flag, any completed read word and a rejected-start flag. Throughput is one
// request per clock cycle while the result channel is not stalled, set by the update
// of the pin sequencer in the back end; each result is registered before it is shown.
// A two-entry queue separates intake from the sequencer and takes new requests
// while an earlier result waits in the result register. phase_ticks (APB, address 0)
// sets how many tick requests each pin phase lasts; write it only while idle.
// Depends on srwm_pkg, srwm_if, srwm_front, srwm_queue and srwm_back.
module serial_register_write_read_master #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  srwm_in_if.sink                        in_ch,
  srwm_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srwm_pkg::PADDR_W-1:0]   paddr,
  input  logic [srwm_pkg::PDATA_W-1:0]   pwdata,
  output logic [srwm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [srwm_pkg::TICKS_W-1:0] phase_ticks_r;
  logic                         cfg_sel;

  logic                  f_valid, f_ready;
  srwm_pkg::cmd_t        f_cmd;
  logic [WORD_BITS-1:0]  f_word;
  logic                  q_valid, q_ready;
  srwm_pkg::cmd_t        q_cmd;
  logic [WORD_BITS-1:0]  q_word;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == srwm_pkg::CFG_IDX_PHASE_TICKS);
  assign prdata  = cfg_sel ? {16'd0, phase_ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= srwm_pkg::PHASE_TICKS_RST;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      phase_ticks_r <= pwdata[srwm_pkg::TICKS_W-1:0];
    end
  end

  srwm_front #(.WORD_BITS(WORD_BITS)) u_front (
    .in_ch     (in_ch),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .cmd_word  (f_word)
  );

  srwm_queue #(.WORD_BITS(WORD_BITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd),
    .pop_word   (q_word)
  );

  srwm_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .cmd_word    (q_word),
    .out_ch      (out_ch)
  );

endmodule
